FILE: src/bsru_pkg.sv
// ----------------------------------------------------------------------------
// bsru_pkg
// Shared types, opcodes and constants for the load-cell ADC serial readout.
// ----------------------------------------------------------------------------
package bsru_pkg;

  // Conversion result bits shifted out on SCK
  localparam int RESULT_BITS = 24;
  // Readout shifts bits RESULT_BITS down to 0, so keep one extra bit
  localparam int SCALED_W    = RESULT_BITS + 1;
  localparam int BIT_IDX_W   = $clog2(SCALED_W);

  localparam logic [7:0] RATE_RESET = 8'd12;

  // Item opcodes
  localparam logic [2:0] OP_SCK_RISE    = 3'd0;
  localparam logic [2:0] OP_SCK_FALL    = 3'd1;
  localparam logic [2:0] OP_LOAD_SCALED = 3'd2;
  localparam logic [2:0] OP_LOAD_RAW    = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  // Gain codes; the unused code behaves as gain 8
  localparam logic [1:0] GAIN_128 = 2'd0;
  localparam logic [1:0] GAIN_64  = 2'd1;
  localparam logic [1:0] GAIN_8   = 2'd2;

  // floor(|s| / 125) estimate: (|s| * RECIP_MULT) >> RECIP_SHIFT, low by at most one
  localparam int          RECIP_SHIFT = 39;
  localparam logic [32:0] RECIP_MULT  = 33'd4398046511;
  localparam int          QUOT_W      = 26;
  localparam logic [7:0]  DIVISOR     = 8'd125;

  typedef struct packed {
    logic [2:0]         op;
    logic               chan_index;
    logic signed [31:0] sample_value;
  } item_t;

  typedef struct packed {
    logic       dout;
    logic       conversion_done;
    logic       channel_b;
    logic [7:0] gain_factor;
  } result_t;

  // Per-channel precomputed divide terms
  typedef struct packed {
    logic              neg;
    logic [QUOT_W-1:0] quot_est;
    logic [7:0]        mag_low;
  } prescale_t;

  function automatic logic [7:0] gain_value(input logic [1:0] code);
    case (code)
      GAIN_128: gain_value = 8'd128;
      GAIN_64:  gain_value = 8'd64;
      default:  gain_value = 8'd8;
    endcase
  endfunction

  // floor(x / 125) for x below 2000
  function automatic logic [3:0] small_div125(input logic [10:0] x);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (x >= 11'(125 * i)) begin
        t = 4'(i);
      end
    end
    small_div125 = t;
  endfunction

endpackage

FILE: src/bsru_in_if.sv
// ----------------------------------------------------------------------------
// bsru_in_if
// Input item channel: opcode, target channel and sample.
// ----------------------------------------------------------------------------
interface bsru_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic               chan_index;
  logic signed [31:0] sample_value;

  modport source (output valid, output op, output chan_index, output sample_value,
                  input ready);
  modport sink   (input valid, input op, input chan_index, input sample_value,
                  output ready);
endinterface

FILE: src/bsru_out_if.sv
// ----------------------------------------------------------------------------
// bsru_out_if
// Result channel: DOUT level, data-ready pulse, channel and gain.
// ----------------------------------------------------------------------------
interface bsru_out_if;
  logic       valid;
  logic       ready;
  logic       dout;
  logic       conversion_done;
  logic       channel_b;
  logic [7:0] gain_factor;

  modport source (output valid, output dout, output conversion_done,
                  output channel_b, output gain_factor, input ready);
  modport sink   (input valid, input dout, input conversion_done,
                  input channel_b, input gain_factor, output ready);
endinterface

FILE: src/bsru_cfg_if.sv
// ----------------------------------------------------------------------------
// bsru_cfg_if
// Configuration write channel for the conversion rate register.
// ----------------------------------------------------------------------------
interface bsru_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bsru_prescale.sv
// ----------------------------------------------------------------------------
// bsru_prescale
// Splits a loaded sample into sign, quotient estimate of |s|/125 and low bits.
// ----------------------------------------------------------------------------
module bsru_prescale
  import bsru_pkg::*;
(
  input  logic signed [31:0] sample,
  output prescale_t          pre
);

  logic [31:0] abs_val;
  logic [64:0] product;

  // -2^31 maps to 0x8000_0000, still correct as unsigned
  assign abs_val = sample[31] ? (~sample + 32'd1) : sample;
  assign product = 65'(abs_val) * 65'(RECIP_MULT);

  assign pre.neg      = sample[31];
  assign pre.quot_est = product[RECIP_SHIFT +: QUOT_W];
  assign pre.mag_low  = abs_val[7:0];

endmodule

FILE: src/bsru_core.sv
// ----------------------------------------------------------------------------
// bsru_core
// ADC state: sample store, conversion, countdown, SCK readout and selection.
// ----------------------------------------------------------------------------
module bsru_core
  import bsru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] rate_ms,
  output result_t    result
);

  // Edges past the readout, counted from the first one after it
  localparam logic [7:0] SEL_A_128 = 8'd1;
  localparam logic [7:0] SEL_B_64  = 8'd2;
  localparam logic [7:0] SEL_A_64  = 8'd3;
  localparam logic [7:0] SEL_B_8   = 8'd4;

  logic                       sel_chan, sel_chan_next;
  logic [1:0]                 gain_code, gain_code_next;
  logic [7:0]                 pulse_count, pulse_count_next;
  logic signed [31:0]         samples [2];
  prescale_t                  pre_store [2];
  logic [1:0]                 raw_flags;
  logic [SCALED_W-1:0]        scaled, scaled_next;
  logic [7:0]                 countdown, countdown_next;
  logic                       dout_level, dout_level_next;
  logic                       done;

  prescale_t                  pre_in;
  prescale_t                  pre_sel;
  logic [7:0]                 quot_low_x;
  logic [7:0]                 rem_est;
  logic                       rem_over;
  logic [6:0]                 rem;
  logic [QUOT_W-1:0]          quot;
  logic [2:0]                 mexp;
  logic [3:0]                 kexp;
  logic [3:0]                 frac_q;
  logic [29:0]                mag;
  logic [SCALED_W-1:0]        mag_w;
  logic [SCALED_W-1:0]        div_result;
  logic signed [38:0]         raw_prod;
  logic [SCALED_W-1:0]        conv_result;
  logic [7:0]                 past_edge;
  logic [BIT_IDX_W-1:0]       bit_idx;

  bsru_prescale u_prescale (
    .sample (item.sample_value),
    .pre    (pre_in)
  );

  // Conversion datapath. trunc(s*2^k/1000) = sign * floor(|s|*2^(k-3)/125),
  // split as q*2^m + floor(r*2^m/125) with q, r from |s|/125.
  always_comb begin
    pre_sel    = pre_store[sel_chan];
    quot_low_x = 8'(pre_sel.quot_est[7:0] * DIVISOR);
    rem_est    = pre_sel.mag_low - quot_low_x;      // exact, below 250
    rem_over   = (rem_est >= DIVISOR);
    rem        = rem_over ? 7'(rem_est - DIVISOR) : rem_est[6:0];
    quot       = pre_sel.quot_est + QUOT_W'(rem_over);
    case (gain_code)
      GAIN_128: begin mexp = 3'd4; kexp = 4'd7; end
      GAIN_64:  begin mexp = 3'd3; kexp = 4'd6; end
      default:  begin mexp = 3'd0; kexp = 4'd3; end
    endcase
    frac_q     = small_div125(11'(rem) << mexp);
    mag        = (30'(quot) << mexp) | 30'(frac_q);
    mag_w      = SCALED_W'(mag);
    div_result = pre_sel.neg ? (~mag_w + SCALED_W'(1)) : mag_w;
    raw_prod   = 39'(samples[sel_chan]) <<< kexp;
    conv_result = raw_flags[sel_chan] ? SCALED_W'(raw_prod) : div_result;
  end

  always_comb begin
    sel_chan_next    = sel_chan;
    gain_code_next   = gain_code;
    pulse_count_next = pulse_count;
    scaled_next      = scaled;
    countdown_next   = countdown;
    dout_level_next  = dout_level;
    done             = 1'b0;
    past_edge        = pulse_count_next - 8'(RESULT_BITS);
    bit_idx          = '0;
    case (item.op)
      OP_SCK_RISE: begin
        pulse_count_next = pulse_count + 8'd1;
        past_edge        = pulse_count_next - 8'(RESULT_BITS);
        bit_idx          = BIT_IDX_W'(RESULT_BITS) - pulse_count_next[BIT_IDX_W-1:0];
        if (pulse_count_next <= 8'(RESULT_BITS)) begin
          dout_level_next = scaled[bit_idx];
        end else begin
          dout_level_next = 1'b1;
          countdown_next  = rate_ms;
          case (past_edge)
            SEL_A_128: begin sel_chan_next = 1'b0; gain_code_next = GAIN_128; end
            SEL_B_64:  begin sel_chan_next = 1'b1; gain_code_next = GAIN_64;  end
            SEL_A_64:  begin sel_chan_next = 1'b0; gain_code_next = GAIN_64;  end
            SEL_B_8:   begin sel_chan_next = 1'b1; gain_code_next = GAIN_8;   end
            default: ;
          endcase
        end
      end
      OP_LOAD_RAW: begin
        countdown_next = rate_ms;
      end
      OP_TICK: begin
        if (countdown <= 8'd1) begin
          scaled_next      = conv_result;
          pulse_count_next = 8'd0;
          dout_level_next  = 1'b0;
          countdown_next   = rate_ms;
          done             = 1'b1;
        end else begin
          countdown_next = countdown - 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_chan     <= 1'b0;
      gain_code    <= GAIN_128;
      pulse_count  <= 8'd0;
      samples[0]   <= '0;
      samples[1]   <= '0;
      pre_store[0] <= '0;
      pre_store[1] <= '0;
      raw_flags    <= 2'b00;
      scaled       <= '0;
      countdown    <= RATE_RESET;
      dout_level   <= 1'b1;
    end else if (step) begin
      sel_chan    <= sel_chan_next;
      gain_code   <= gain_code_next;
      pulse_count <= pulse_count_next;
      scaled      <= scaled_next;
      countdown   <= countdown_next;
      dout_level  <= dout_level_next;
      if (item.op == OP_LOAD_SCALED || item.op == OP_LOAD_RAW) begin
        samples[item.chan_index]   <= item.sample_value;
        pre_store[item.chan_index] <= pre_in;
        raw_flags[item.chan_index] <= (item.op == OP_LOAD_RAW);
      end
    end
  end

  assign result.dout            = dout_level_next;
  assign result.conversion_done = done;
  assign result.channel_b       = sel_chan_next;
  assign result.gain_factor     = gain_value(gain_code_next);

endmodule

FILE: src/bridge_adc_serial_readout_unit.sv
// ----------------------------------------------------------------------------
// bridge_adc_serial_readout_unit
// Two-channel load-cell ADC model with clocked serial readout.
// ----------------------------------------------------------------------------
// Path: an item passes the input register, then the result register,
//   which offers its result.
// Throughput: one item per cycle, one bsru_core pass, unless out_ch stalls.
// Reset: synchronous; rate_reg returns to 12, core state and valid flags to
//   their reset values, and the item and rate channels are open after reset.
// ----------------------------------------------------------------------------
module bridge_adc_serial_readout_unit
  import bsru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bsru_in_if.sink     in_ch,
  bsru_out_if.source  out_ch,
  bsru_cfg_if.sink    cfg
);

  logic       rate_ms;
  logic [7:0] rate_reg;
  logic       in_vld;
  item_t      in_item;
  logic       out_vld;
  result_t    out_res;
  logic       advance;
  result_t    core_res;

  // Rate register; the user writes only while the block is idle (not enforced)
  assign cfg.ready = 1'b1;
  assign rate_ms   = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= RATE_RESET;
    end else if (rate_ms) begin
      rate_reg <= cfg.data;
    end
  end

  // The held item moves to the result register when that slot is free or
  // being drained this cycle; the input register then frees at once, so a
  // new transfer can follow every cycle.
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item.op           <= in_ch.op;
      in_item.chan_index   <= in_ch.chan_index;
      in_item.sample_value <= in_ch.sample_value;
    end
  end

  // State update and result of the held item happen in the same cycle
  bsru_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_item),
    .rate_ms (rate_reg),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign out_ch.valid           = out_vld;
  assign out_ch.dout            = out_res.dout;
  assign out_ch.conversion_done = out_res.conversion_done;
  assign out_ch.channel_b       = out_res.channel_b;
  assign out_ch.gain_factor     = out_res.gain_factor;

endmodule

FILE: sim/bridge_adc_serial_readout_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_adc_serial_readout_checker
// Passive pin-state checker: tracks the ADC state from accepted item and
// rate transfers, and matches every result transfer against the oldest
// predicted pin state.
// ----------------------------------------------------------------------------
module bridge_adc_serial_readout_checker
  import bsru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bsru_in_if          in_ch,
  bsru_out_if         out_ch,
  bsru_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned results_due
);

  localparam int SCALE_DIV = 1000;

  logic [7:0]         rate_ms;
  logic               sel_chan;
  logic [1:0]         gain_code;
  logic [7:0]         rise_count;
  logic signed [31:0] sample_mem [2];
  logic               raw_mem [2];
  logic [39:0]        conv_word;
  logic [7:0]         countdown;
  logic               dout_level;
  result_t            pin_queue [$];
  int unsigned        fails = 0;

  function automatic logic [7:0] gain_factor_of(input logic [1:0] code);
    return (code == GAIN_128) ? 8'd128 : (code == GAIN_64) ? 8'd64 : 8'd8;
  endfunction

  // Advance the ADC state by one item and queue the pin state it leaves.
  task step_adc(input logic [2:0] op, input logic ch, input logic signed [31:0] s);
    longint  prod;
    logic    done;
    result_t pins;
    done = 1'b0;
    case (op)
      OP_SCK_RISE: begin
        rise_count = rise_count + 8'd1;
        // count 0 after wrap still lies in the shift range (top bit)
        if (rise_count <= 8'(RESULT_BITS)) begin
          dout_level = conv_word[RESULT_BITS - rise_count];
        end else begin
          dout_level = 1'b1;
          case (rise_count - 8'(RESULT_BITS))
            8'd1: begin
              sel_chan  = 1'b0;
              gain_code = GAIN_128;
            end
            8'd2: begin
              sel_chan  = 1'b1;
              gain_code = GAIN_64;
            end
            8'd3: begin
              sel_chan  = 1'b0;
              gain_code = GAIN_64;
            end
            8'd4: begin
              sel_chan  = 1'b1;
              gain_code = GAIN_8;
            end
            default: ;
          endcase
          countdown = rate_ms;
        end
      end
      OP_LOAD_SCALED, OP_LOAD_RAW: begin
        sample_mem[ch] = s;
        raw_mem[ch]    = (op == OP_LOAD_RAW);
        if (op == OP_LOAD_RAW) begin
          countdown = rate_ms;
        end
      end
      OP_TICK: begin
        if (countdown <= 8'd1) begin
          prod = longint'(sample_mem[sel_chan]) * longint'(gain_factor_of(gain_code));
          if (!raw_mem[sel_chan]) begin
            prod = prod / SCALE_DIV;
          end
          conv_word  = prod[39:0];
          rise_count = 8'd0;
          dout_level = 1'b0;
          countdown  = rate_ms;
          done       = 1'b1;
        end else begin
          countdown = countdown - 8'd1;
        end
      end
      default: ;  // falling SCK and spare codes leave state alone
    endcase
    pins.dout            = dout_level;
    pins.conversion_done = done;
    pins.channel_b       = sel_chan;
    pins.gain_factor     = gain_factor_of(gain_code);
    pin_queue.push_back(pins);
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t due;
    if (rst) begin
      rate_ms       = RATE_RESET;
      sel_chan      = 1'b0;
      gain_code     = GAIN_128;
      rise_count    = 8'd0;
      sample_mem[0] = '0;
      sample_mem[1] = '0;
      raw_mem[0]    = 1'b0;
      raw_mem[1]    = 1'b0;
      conv_word     = '0;
      countdown     = RATE_RESET;
      dout_level    = 1'b1;
      pin_queue.delete();
    end else begin
      // a result trails its item via the input and result regs; order is free
      if (out_ch.valid && out_ch.ready) begin
        seen.dout            = out_ch.dout;
        seen.conversion_done = out_ch.conversion_done;
        seen.channel_b       = out_ch.channel_b;
        seen.gain_factor     = out_ch.gain_factor;
        if (pin_queue.size() == 0) begin
          $display("%0t: result transfer with none pending, expected none",
                   $time);
          $display("%0t:   got dout=%b done=%b chan_b=%b gain=%0d",
                   $time, seen.dout, seen.conversion_done, seen.channel_b,
                   seen.gain_factor);
          fails++;
        end else begin
          due = pin_queue.pop_front();
          if (seen !== due) begin
            $display("%0t: pin state mismatch, expected dout=%b done=%b chan_b=%b gain=%0d",
                     $time, due.dout, due.conversion_done, due.channel_b, due.gain_factor);
            $display("%0t:                        got dout=%b done=%b chan_b=%b gain=%0d",
                     $time, seen.dout, seen.conversion_done, seen.channel_b, seen.gain_factor);
            fails++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        rate_ms = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        step_adc(in_ch.op, in_ch.chan_index, in_ch.sample_value);
      end
    end
    fail_count  <= fails;
    results_due <= pin_queue.size();
  end

endmodule

FILE: sim/bridge_adc_serial_readout_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_adc_serial_readout_unit_tb
// Drives the load-cell ADC readout with a short directed opener and then
// random conversion/readout sequences over several conversion rates, with
// random gaps and stalls on both channels. A side checker predicts every
// pin state; this module only makes traffic and reports the verdict.
// ----------------------------------------------------------------------------
module bridge_adc_serial_readout_unit_tb;
  import bsru_pkg::*;

  // Codes with no meaning to the block; it must report state and move on
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  // Slowest legal run is ~1800 items; keep several x margin
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  // Long receiver hold-off, far deeper than any buffering in the block
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Quiet cycles after the last result before a rate write or the verdict
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned PHASE_ITEMS     = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_count  = 0;
  int unsigned stall_asks   = 0;
  int unsigned stall_served = 0;
  int unsigned live_items   = 0;
  logic [7:0]  rate_now     = RATE_RESET;
  int unsigned fail_count;
  int unsigned results_due;

  bsru_in_if  in_ch ();
  bsru_out_if out_ch ();
  bsru_cfg_if cfg_ch ();

  bridge_adc_serial_readout_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  bridge_adc_serial_readout_checker pin_monitor (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Samples lean on the interesting spots: zero, +-1, both rails, values
  // around the divide-by-1000 boundary, plus plain random words.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sd0;
      1:       return -32'sd1;
      2:       return 32'sh7fffffff;
      3:       return 32'sh80000000;
      4:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      5:       return $signed(32'($urandom_range(1, 16)));
      default: return $signed($urandom);
    endcase
  endfunction

  // Sender idle: mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One item transfer. Valid stays high across back-to-back items, so it
  // is only lowered when a gap is inserted.
  task automatic offer_item(input logic [2:0] op, input logic ch,
                            input logic signed [31:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.chan_index   <= ch;
    in_ch.sample_value <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_SCK_RISE || op == OP_LOAD_SCALED || op == OP_LOAD_RAW || op == OP_TICK) begin
      live_items++;
    end
  endtask

  // Let every pending result out, then a few idle cycles before touching
  // the rate register or ending the run.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    rate_now = v;
  endtask

  // Random traffic. Most of it is the real pin protocol: load samples,
  // tick until a conversion, clock the word out and pick the next channel
  // and gain. The rest is short broken readouts, stray ticks and noise.
  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    int unsigned r;
    stop_at = live_items + budget;
    // one long receiver hold-off per phase, while items keep coming
    stall_asks++;
    while (live_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        repeat ($urandom_range(0, 2)) begin
          offer_item(coin() ? OP_LOAD_RAW : OP_LOAD_SCALED, coin(), pick_sample());
        end
        // a full countdown period after the last reload fires a conversion
        repeat (rate_now) begin
          if ($urandom_range(0, 9) == 0) begin
            offer_item(OP_SCK_FALL, coin(), $signed($urandom));
          end
          offer_item(OP_TICK, coin(), $signed($urandom));
        end
        // usually 25..28 rising edges; sometimes a truncated or overlong burst
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 34)
                                        : RESULT_BITS + $urandom_range(1, 4);
        repeat (n) begin
          if (coin()) begin
            offer_item(OP_SCK_FALL, coin(), $signed($urandom));
          end
          if ($urandom_range(0, 19) == 0) begin
            offer_item(OP_TICK, coin(), $signed($urandom));
          end
          offer_item(OP_SCK_RISE, coin(), $signed($urandom));
        end
      end else if (r < 85) begin
        // noise across all eight codes, spare ones included
        repeat ($urandom_range(1, 8)) begin
          offer_item(3'($urandom_range(0, 7)), coin(), pick_sample());
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          offer_item(coin() ? OP_LOAD_RAW : OP_LOAD_SCALED, coin(), pick_sample());
        end
      end
    end
  endtask

  // Result side: random ready pattern, plus the long hold-off on request.
  initial begin : receiver
    int unsigned r;
    int unsigned hold;
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (stall_served != stall_asks) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        stall_served++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SCK_FALL;
    in_ch.chan_index   = 1'b0;
    in_ch.sample_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = RATE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed opener at the reset rate ---
    offer_item(OP_TICK, 1'b0, '0);              // countdown just decrements
    offer_item(OP_SCK_FALL, 1'b1, 32'sh7fffffff); // falling edge: no effect
    offer_item(OP_SPARE_A, 1'b0, '0);
    offer_item(OP_SPARE_B, 1'b1, -32'sd1);
    offer_item(OP_SPARE_C, 1'b0, 32'sh80000000);
    offer_item(OP_SCK_RISE, 1'b0, '0);          // shifts a bit of the reset word
    drain();

    // --- directed opener at the fastest rate ---
    write_rate(8'd1);
    offer_item(OP_LOAD_RAW, 1'b1, 32'sh80000000);    // raw load reloads countdown
    offer_item(OP_LOAD_SCALED, 1'b0, 32'sh7fffffff);
    offer_item(OP_TICK, 1'b1, '0);                   // converts A, positive rail
    repeat (3) offer_item(OP_SCK_RISE, 1'b1, '0);
    offer_item(OP_LOAD_SCALED, 1'b0, 32'sh80000000);
    offer_item(OP_TICK, 1'b0, '0);                   // negative rail, trunc to zero
    offer_item(OP_LOAD_RAW, 1'b0, -32'sd1);
    offer_item(OP_TICK, 1'b0, '0);                   // raw path skips the divide
    offer_item(OP_LOAD_SCALED, 1'b1, -32'sd999);
    offer_item(OP_LOAD_SCALED, 1'b1, 32'sd7);
    repeat (2) offer_item(OP_SCK_RISE, 1'b0, '0);

    run_random(PHASE_ITEMS);
    drain();

    // slowest rate: only a conversion or so fits in the phase
    write_rate(8'd255);
    run_random(PHASE_ITEMS);
    drain();

    // reset rate again; a long SCK burst wraps the 8-bit pulse count
    write_rate(RATE_RESET);
    repeat (260) offer_item(OP_SCK_RISE, coin(), $signed($urandom));
    run_random(PHASE_ITEMS);
    drain();

    write_rate(8'($urandom_range(2, 40)));
    run_random(PHASE_ITEMS);
    drain();

    write_rate(8'd2);
    run_random(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
